/* hw/rtl/bmrf_pkg.sv */
// ----------------------------------------------------------------------------
// bmrf_pkg
// Shared types, codes and mask helper for the row range fill and probe bitmap.
// ----------------------------------------------------------------------------
package bmrf_pkg;

  localparam int unsigned WORD_SEL_W = 3;
  localparam int unsigned CFG_W      = 9;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_SET   = 2'd1;
  localparam logic [1:0] ACT_CHECK = 2'd2;

  localparam logic [0:0] CFG_ROWS_IN_USE = 1'b0;
  localparam logic [0:0] CFG_COLS_IN_USE = 1'b1;

  localparam logic [CFG_W-1:0] CFG_RESET_VAL = 9'd256;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_SET,
    CMD_CHECK
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic                  rejected;
    logic [7:0]            row;
    logic [WORD_SEL_W-1:0] wlo;
    logic [WORD_SEL_W-1:0] whi;
    logic [5:0]            lo_bit;
    logic [5:0]            hi_bit;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic rejected;
  } res_t;

  // Columns run MSB first: keep bits lo_bit..hi_bit counted from bit 63 down.
  function automatic logic [63:0] range_mask(input logic       is_first,
                                             input logic       is_last,
                                             input logic [5:0] lo_bit,
                                             input logic [5:0] hi_bit);
    logic [5:0] s;
    logic [5:0] e;
    s = is_first ? lo_bit : 6'd0;
    e = is_last ? hi_bit : 6'd63;
    return ({64{1'b1}} >> s) & ({64{1'b1}} << (6'd63 - e));
  endfunction

endpackage

/* hw/rtl/bmrf_fifo.sv */
// ----------------------------------------------------------------------------
// bmrf_fifo
// Small synchronous queue with full and empty flags.
// ----------------------------------------------------------------------------
module bmrf_fifo #(
  parameter int unsigned W     = 2,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slot_q [DEPTH];
  logic [PW-1:0] wr_ptr_q;
  logic [PW-1:0] rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push;
  logic          do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

/* hw/rtl/bmrf_front.sv */
// ----------------------------------------------------------------------------
// bmrf_front
// Bounds test and decode of a request into a word-level command.
// ----------------------------------------------------------------------------
module bmrf_front #(
  parameter int unsigned MAX_ROWS      = 256,
  parameter int unsigned WORDS_PER_ROW = 4
) (
  input  logic [1:0]         action_i,
  input  logic [7:0]         row_i,
  input  logic [7:0]         first_col_i,
  input  logic [8:0]         end_col_i,
  input  logic [8:0]         rows_in_use_i,
  input  logic [8:0]         cols_in_use_i,
  output bmrf_pkg::cmd_t     cmd_o
);
  import bmrf_pkg::*;

  localparam logic [12:0] MaxRowsV   = 13'(MAX_ROWS);
  localparam logic [12:0] TotalColsV = 13'(64 * WORDS_PER_ROW);

  logic       row_ok;
  logic       first_ok;
  logic       end_ok;
  logic [8:0] end_m1;

  assign row_ok   = ({1'b0, row_i} < rows_in_use_i) && (13'(row_i) < MaxRowsV);
  assign first_ok = ({1'b0, first_col_i} < cols_in_use_i)
                    && (13'(first_col_i) < TotalColsV);
  assign end_ok   = (end_col_i <= cols_in_use_i) && (13'(end_col_i) <= TotalColsV);
  assign end_m1   = end_col_i - 9'd1;

  always_comb begin
    cmd_o          = '0;
    cmd_o.row      = row_i;
    cmd_o.wlo      = {1'b0, first_col_i[7:6]};
    cmd_o.whi      = end_m1[8:6];
    cmd_o.lo_bit   = first_col_i[5:0];
    cmd_o.hi_bit   = end_m1[5:0];
    cmd_o.kind     = CMD_NONE;
    cmd_o.rejected = 1'b0;
    case (action_i)
      ACT_CLEAR: begin
        cmd_o.kind = CMD_CLEAR;
      end
      ACT_SET: begin
        if (!(row_ok && first_ok && end_ok)) begin
          cmd_o.rejected = 1'b1;
        end else if (end_col_i > {1'b0, first_col_i}) begin
          cmd_o.kind = CMD_SET;
        end
      end
      ACT_CHECK: begin
        if (row_ok && first_ok) begin
          cmd_o.kind = CMD_CHECK;
        end else begin
          cmd_o.rejected = 1'b1;
        end
      end
      default: begin
        cmd_o.rejected = 1'b1;
      end
    endcase
  end

endmodule

/* hw/rtl/bmrf_back.sv */
// ----------------------------------------------------------------------------
// bmrf_back
// Command engine: word store, clear sweep, read-modify-write fill and probe.
// ----------------------------------------------------------------------------
module bmrf_back #(
  parameter int unsigned MAX_ROWS      = 256,
  parameter int unsigned WORDS_PER_ROW = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bmrf_pkg::cmd_t cmd_i,
  input  logic           cmd_empty_i,
  output logic           cmd_pop_o,
  input  logic           res_full_i,
  output logic           res_push_o,
  output bmrf_pkg::res_t res_o,
  output logic           init_busy_o
);
  import bmrf_pkg::*;

  localparam int unsigned Total = MAX_ROWS * WORDS_PER_ROW;
  localparam int unsigned AW    = (Total > 1) ? $clog2(Total) : 1;
  localparam logic [AW-1:0] LastAddr = AW'(Total - 1);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SET_RD,
    ST_SET_WR,
    ST_CHK_RD,
    ST_CHK_BIT,
    ST_RESP
  } state_e;

  state_e                state_q;
  cmd_t                  cmd_q;
  res_t                  res_q;
  logic [WORD_SEL_W-1:0] w_q;
  logic [AW-1:0]         sweep_q;
  logic [63:0]           mem_q [Total];
  logic [63:0]           rdata_q;

  logic [AW-1:0]         word_addr;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [63:0]           mem_wdata;
  logic                  mem_re;

  assign word_addr   = AW'(32'(cmd_q.row) * WORDS_PER_ROW + 32'(w_q));
  assign cmd_pop_o   = (state_q == ST_IDLE) && !cmd_empty_i;
  assign res_push_o  = (state_q == ST_RESP);
  assign res_o       = res_q;
  assign init_busy_o = (state_q == ST_INIT);
  assign mem_re      = (state_q == ST_SET_RD) || (state_q == ST_CHK_RD);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = word_addr;
    mem_wdata = rdata_q | range_mask(w_q == cmd_q.wlo, w_q == cmd_q.whi,
                                     cmd_q.lo_bit, cmd_q.hi_bit);
    case (state_q)
      ST_INIT, ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = '0;
      end
      ST_SET_WR: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[word_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      sweep_q <= '0;
      cmd_q   <= '0;
      res_q   <= '0;
      w_q     <= '0;
    end else begin
      case (state_q)
        ST_INIT: begin
          sweep_q <= sweep_q + AW'(1);
          if (sweep_q == LastAddr) begin
            sweep_q <= '0;
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!cmd_empty_i) begin
            cmd_q <= cmd_i;
            w_q   <= cmd_i.wlo;
            case (cmd_i.kind)
              CMD_CLEAR: state_q <= ST_CLEAR;
              CMD_SET:   state_q <= ST_SET_RD;
              CMD_CHECK: state_q <= ST_CHK_RD;
              default: begin
                res_q.hit      <= 1'b0;
                res_q.rejected <= cmd_i.rejected;
                state_q        <= ST_RESP;
              end
            endcase
          end
        end
        ST_CLEAR: begin
          sweep_q <= sweep_q + AW'(1);
          if (sweep_q == LastAddr) begin
            sweep_q <= '0;
            res_q   <= '0;
            state_q <= ST_RESP;
          end
        end
        ST_SET_RD: begin
          state_q <= ST_SET_WR;
        end
        ST_SET_WR: begin
          if (w_q == cmd_q.whi) begin
            res_q   <= '0;
            state_q <= ST_RESP;
          end else begin
            w_q     <= w_q + WORD_SEL_W'(1);
            state_q <= ST_SET_RD;
          end
        end
        ST_CHK_RD: begin
          state_q <= ST_CHK_BIT;
        end
        ST_CHK_BIT: begin
          res_q.hit      <= rdata_q[~cmd_q.lo_bit];
          res_q.rejected <= 1'b0;
          state_q        <= ST_RESP;
        end
        ST_RESP: begin
          if (!res_full_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/bitmap_row_range_fill_and_probe.sv */
// ----------------------------------------------------------------------------
// bitmap_row_range_fill_and_probe
// Occupancy bitmap of MAX_ROWS rows by WORDS_PER_ROW 64-bit words, columns
// numbered from the MSB, with whole-map clear, row range set and bit probe.
// ----------------------------------------------------------------------------
// Every request yields one result. After reset the map is swept to zero, one
// word per cycle, and full stays high until the sweep ends. All work goes
// through one single-port word store: a clear sweeps every word to zero, a set
// reads and rewrites each word it touches in turn, a check reads one word and
// then tests the bit, and a rejected request or an empty range goes straight
// to its result. A two-entry command queue sits in front of the engine and a
// two-entry result queue behind it.
module bitmap_row_range_fill_and_probe #(
  parameter int unsigned MAX_ROWS      = 256,
  parameter int unsigned WORDS_PER_ROW = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] action_i,
  input  logic [7:0] row_i,
  input  logic [7:0] first_col_i,
  input  logic [8:0] end_col_i,
  output logic       empty,
  input  logic       pop,
  output logic       hit_o,
  output logic       rejected_o,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_addr_i,
  input  logic [8:0] cfg_wdata_i
);
  import bmrf_pkg::*;

  logic [CFG_W-1:0] rows_in_use_q;
  logic [CFG_W-1:0] cols_in_use_q;
  cmd_t             cmd_in;
  cmd_t             cmd_head;
  logic [$bits(cmd_t)-1:0] cmd_head_raw;
  logic             cmd_full;
  logic             cmd_empty;
  logic             cmd_pop;
  logic             res_full;
  logic             res_push;
  res_t             res_in;
  res_t             res_head;
  logic [$bits(res_t)-1:0] res_head_raw;
  logic             init_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_in_use_q <= CFG_RESET_VAL;
      cols_in_use_q <= CFG_RESET_VAL;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_ROWS_IN_USE: rows_in_use_q <= cfg_wdata_i;
        CFG_COLS_IN_USE: cols_in_use_q <= cfg_wdata_i;
        default: rows_in_use_q <= rows_in_use_q;
      endcase
    end
  end

  assign full = cmd_full || init_busy;

  bmrf_front #(
    .MAX_ROWS      (MAX_ROWS),
    .WORDS_PER_ROW (WORDS_PER_ROW)
  ) u_front (
    .action_i      (action_i),
    .row_i         (row_i),
    .first_col_i   (first_col_i),
    .end_col_i     (end_col_i),
    .rows_in_use_i (rows_in_use_q),
    .cols_in_use_i (cols_in_use_q),
    .cmd_o         (cmd_in)
  );

  bmrf_fifo #(
    .W     ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && !init_busy),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head_raw),
    .empty_o (cmd_empty)
  );

  assign cmd_head = cmd_t'(cmd_head_raw);

  bmrf_back #(
    .MAX_ROWS      (MAX_ROWS),
    .WORDS_PER_ROW (WORDS_PER_ROW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .init_busy_o (init_busy)
  );

  bmrf_fifo #(
    .W     ($bits(res_t)),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_head_raw),
    .empty_o (empty)
  );

  assign res_head   = res_t'(res_head_raw);
  assign hit_o      = res_head.hit;
  assign rejected_o = res_head.rejected;

endmodule

/* hw/rtl/bmrf_checker.sv */
// ----------------------------------------------------------------------------
// bmrf_checker
// Port-level checks on the bitmap block, bound to its top level.
// ----------------------------------------------------------------------------
module bmrf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input logic hit_o,
  input logic rejected_o
);

  // A probe hit is never reported on a refused request.
  a_hit_not_rejected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(hit_o && rejected_o))
    else $error("hit and rejected both set");

  // The map is swept clean right after reset, so no request is taken then.
  a_full_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rst_ni && !$past(rst_ni)) |-> full)
    else $error("request taken during reset sweep");

  // A waiting result stays until its transfer.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result dropped without transfer");

  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> ($stable(hit_o) && $stable(rejected_o)))
    else $error("waiting result changed");

endmodule

bind bitmap_row_range_fill_and_probe bmrf_checker u_bmrf_checker (.*);
